// ===== design/oal_pkg.sv =====
// shared types and constants for the ordered array list unit
package oal_pkg;

   localparam int DEPTH   = 64;
   localparam int POS_W   = 6;
   localparam int VAL_W   = 32;
   localparam int CNT_W   = 7;
   localparam int FUNC_W  = 2;
   localparam int STAT_W  = 2;
   localparam int REQ_DW  = 40;
   localparam int RSP_DW  = 40;
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_GET    = 2'd1,
      FUNC_DELETE = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_LOAD       = 2'd1,
      CELL_FROM_LOWER = 2'd2,
      CELL_FROM_UPPER = 2'd3
   } cell_cmd_type;

endpackage

// ===== design/oal_cell.sv =====
// one list entry: holds, loads or takes its neighbor's entry
module oal_cell
   import oal_pkg::*;
(
   input  logic             clock,
   input  cell_cmd_type     cmd,
   input  logic [VAL_W-1:0] load_data,
   input  logic [VAL_W-1:0] lower_data,
   input  logic [VAL_W-1:0] upper_data,
   output logic [VAL_W-1:0] data
);

   logic [VAL_W-1:0] data_ff;
   logic [VAL_W-1:0] data_in;

   always_comb begin
      case (cmd)
         CELL_HOLD:       data_in = data_ff;
         CELL_LOAD:       data_in = load_data;
         CELL_FROM_LOWER: data_in = lower_data;
         CELL_FROM_UPPER: data_in = upper_data;
         default:         data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== design/ordered_array_list_unit.sv =====
// top level of the ordered array list unit: control, cell row and result register
// a result is written into the output register when its request transfers
// throughput: one request per cycle unless the receiver stalls; the cell row shifts all entries in parallel
// a request is taken whenever the output register is empty or being emptied
// reset: synchronous, clears the length, the output register valid and sets capacity to 64
// entry contents are not cleared; only entries below the length are ever read
module ordered_array_list_unit
   import oal_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,   // pos[5:0], value[37:6], zero pad
   input  logic [FUNC_W-1:0] req_tuser,   // func[1:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,   // read_value[31:0], count[38:32], zero pad
   output logic [STAT_W-1:0] rsp_tuser,   // status[1:0]
   input  logic              csr_wr_en,
   input  logic [CNT_W-1:0]  csr_wr_data
);

   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              req_fire;
   func_type          func;
   logic [POS_W-1:0]  pos;
   logic [VAL_W-1:0]  value;
   logic [CNT_W-1:0]  pos_ext;
   logic [CNT_W-1:0]  cap_eff;
   logic [CNT_W-1:0]  ins_pos;
   logic              ins_ok;
   logic              del_ok;
   logic [VAL_W-1:0]  sel_data;
   logic [VAL_W-1:0]  cell_data [DEPTH];
   cell_cmd_type      cell_cmd  [DEPTH];

   assign func     = func_type'(req_tuser);
   assign pos      = req_tdata[POS_W-1:0];
   assign value    = req_tdata[POS_W +: VAL_W];
   assign pos_ext  = CNT_W'(pos);
   assign cap_eff  = (cap_ff > DEPTH_CNT) ? DEPTH_CNT : cap_ff;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire = req_tvalid && req_tready;
   assign ins_pos  = (pos_ext > len_ff) ? len_ff : pos_ext;
   assign ins_ok   = req_fire && (func == FUNC_INSERT) && (len_ff < cap_eff)
                     && (pos_ext < cap_eff);
   assign del_ok   = req_fire && (func == FUNC_DELETE) && (pos_ext < len_ff);
   assign sel_data = cell_data[pos];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
      logic [VAL_W-1:0] lower;
      logic [VAL_W-1:0] upper;

      if (i == 0) begin : g_first
         assign lower = '0;
      end else begin : g_mid_lo
         assign lower = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign upper = '0;
      end else begin : g_mid_hi
         assign upper = cell_data[i+1];
      end

      always_comb begin
         cell_cmd[i] = CELL_HOLD;
         if (ins_ok) begin
            if (IDX == ins_pos) begin
               cell_cmd[i] = CELL_LOAD;
            end else if ((IDX > ins_pos) && (IDX <= len_ff)) begin
               cell_cmd[i] = CELL_FROM_LOWER;
            end
         end else if (del_ok) begin
            if ((IDX >= pos_ext) && (IDX + CNT_W'(1) < len_ff)) begin
               cell_cmd[i] = CELL_FROM_UPPER;
            end
         end
      end

      oal_cell u_cell (
         .clock      (clock),
         .cmd        (cell_cmd[i]),
         .load_data  (value),
         .lower_data (lower),
         .upper_data (upper),
         .data       (cell_data[i])
      );
   end

   always_comb begin
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      len_in        = len_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (req_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = ST_OK;
         case (func)
            FUNC_INSERT: begin
               if (len_ff >= cap_eff) begin
                  rsp_status_in = ST_FULL;
               end else if (pos_ext >= cap_eff) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  len_in = len_ff + CNT_W'(1);
               end
            end
            FUNC_GET: begin
               if (pos_ext >= len_ff) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  rsp_value_in = sel_data;
               end
            end
            FUNC_DELETE: begin
               if (pos_ext >= len_ff) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  rsp_value_in = sel_data;
                  len_in       = len_ff - CNT_W'(1);
               end
            end
            FUNC_CLEAR: begin
               len_in = '0;
            end
            default: begin
               len_in = len_ff;
            end
         endcase
         rsp_count_in = len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'({rsp_count_ff, rsp_value_ff});
   assign rsp_tuser  = rsp_status_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= DEPTH_CNT)
      else $error("list length above store depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_fire && (func == FUNC_CLEAR) |=> (len_ff == '0) && (rsp_count_ff == '0))
      else $error("clear did not empty the list");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ins_ok |=> (len_ff == $past(len_ff) + CNT_W'(1)) && (rsp_status_ff == ST_OK))
      else $error("successful insert did not grow the list");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      del_ok |=> (len_ff == $past(len_ff) - CNT_W'(1)) && (rsp_count_ff == len_ff))
      else $error("successful delete did not shrink the list");

   a_fail_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_OK) |-> (rsp_value_ff == '0))
      else $error("failed operation returned a value");

endmodule

// ===== tb/tb_ordered_array_list_unit.sv =====
// self-checking testbench for the ordered array list unit: directed and random list operations
module tb_ordered_array_list_unit
   import oal_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_LEN = 200;

   typedef struct packed {
      func_type          func;
      logic [POS_W-1:0]  pos;
      logic [VAL_W-1:0]  value;
   } list_req_type;

   typedef struct packed {
      status_type        status;
      logic [VAL_W-1:0]  read_value;
      logic [CNT_W-1:0]  count;
   } list_rsp_type;

   typedef struct packed {
      logic [DEPTH-1:0][VAL_W-1:0] cells;
      logic [CNT_W-1:0]            length;
      logic [CNT_W-1:0]            cap;
   } list_state_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata = '0;   // pos[5:0], value[37:6], zero pad
   logic [FUNC_W-1:0] req_tuser = '0;   // func[1:0]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;       // read_value[31:0], count[38:32], zero pad
   logic [STAT_W-1:0] rsp_tuser;       // status[1:0]
   logic              csr_wr_en = 1'b0;
   logic [CNT_W-1:0]  csr_wr_data = '0;

   list_req_type   pending_reqs[$];
   list_rsp_type   expected_rsps[$];
   list_req_type   offered;
   list_state_type plan_list;
   list_state_type live_list;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             holds_asked = 0;
   int             holds_served = 0;
   int             hold_left = 0;
   int             mismatches = 0;

   ordered_array_list_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // list behavior: updates the state and gives the response for one request
   task automatic list_apply(inout list_state_type s, input list_req_type r,
                             output list_rsp_type o);
      int lim;
      int p;
      int i;
      lim = (s.cap > DEPTH_CNT) ? DEPTH : int'(s.cap);
      o.status = ST_OK;
      o.read_value = '0;
      case (r.func)
         FUNC_INSERT: begin
            if (int'(s.length) >= lim) begin
               o.status = ST_FULL;
            end else if (int'(r.pos) >= lim) begin
               o.status = ST_RANGE;
            end else begin
               p = (r.pos > s.length) ? int'(s.length) : int'(r.pos);
               for (i = int'(s.length); i > p; i--) s.cells[i] = s.cells[i-1];
               s.cells[p] = r.value;
               s.length = s.length + 1'b1;
            end
         end
         FUNC_GET: begin
            if (r.pos >= s.length) o.status = ST_RANGE;
            else o.read_value = s.cells[r.pos];
         end
         FUNC_DELETE: begin
            if (r.pos >= s.length) begin
               o.status = ST_RANGE;
            end else begin
               o.read_value = s.cells[r.pos];
               for (i = int'(r.pos) + 1; i < int'(s.length); i++) s.cells[i-1] = s.cells[i];
               s.length = s.length - 1'b1;
            end
         end
         default: s.length = '0;
      endcase
      o.count = s.length;
   endtask

   function automatic bit all_settled();
      return pending_reqs.size() == 0 && !req_tvalid && expected_rsps.size() == 0;
   endfunction

   // driver
   always @(posedge clock) begin
      list_rsp_type pred;
      list_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            list_apply(live_list, offered, pred);
            expected_rsps.push_back(pred);
         end
         if (!(req_tvalid && !req_tready)) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               offered = nxt;
               req_tvalid <= 1'b1;
               req_tdata <= {2'b00, nxt.value, nxt.pos};
               req_tuser <= nxt.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver with random stalls and on-demand long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served = holds_served + 1;
         hold_left = HOLD_LEN;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsps.size() == 0) begin
            $error("rsp transfer with no request outstanding");
            mismatches = mismatches + 1;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               mismatches = mismatches + 1;
            end
            if (rsp_tdata[31:0] !== want.read_value) begin
               $error("read_value: expected %h, actual %h", want.read_value, rsp_tdata[31:0]);
               mismatches = mismatches + 1;
            end
            if (rsp_tdata[38:32] !== want.count) begin
               $error("count: expected %0d, actual %0d", want.count, rsp_tdata[38:32]);
               mismatches = mismatches + 1;
            end
         end
      end
   end

   task automatic queue_req(input func_type f, input int pos, input logic [VAL_W-1:0] v);
      list_req_type r;
      list_rsp_type unused;
      r.func = f;
      r.pos = POS_W'(pos);
      r.value = v;
      list_apply(plan_list, r, unused);
      pending_reqs.push_back(r);
   endtask

   task automatic queue_random(input int n, input int insert_pct, input int clear_pct);
      int roll;
      int pos;
      int len;
      func_type f;
      repeat (n) begin
         roll = $urandom_range(99);
         if (roll < clear_pct) f = FUNC_CLEAR;
         else if (roll < clear_pct + insert_pct) f = FUNC_INSERT;
         else if (roll[0]) f = FUNC_GET;
         else f = FUNC_DELETE;
         len = int'(plan_list.length);
         if ($urandom_range(99) < 60 && len > 0) begin
            if (f == FUNC_INSERT) pos = (len > 63) ? 63 : $urandom_range(len);
            else pos = $urandom_range(len - 1);
         end else begin
            pos = $urandom_range(63);
         end
         queue_req(f, pos, $urandom());
      end
   endtask

   task automatic wait_settled();
      while (!all_settled()) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] cap);
      wait_settled();
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      plan_list.cap = cap;
      live_list.cap = cap;
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      wait_settled();
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      plan_list = '0;
      plan_list.cap = CAP_RESET;
      live_list = plan_list;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset capacity, empty-list errors, append, shifts in both directions
      queue_req(FUNC_GET, 0, 32'h0);
      queue_req(FUNC_DELETE, 63, 32'h0);
      queue_req(FUNC_INSERT, 0, 32'hFFFF_FFFF);
      queue_req(FUNC_INSERT, 63, 32'h0000_0000);
      queue_req(FUNC_INSERT, 0, 32'hA5A5_A5A5);
      queue_req(FUNC_INSERT, 1, 32'h5A5A_5A5A);
      queue_req(FUNC_GET, 0, 32'h0);
      queue_req(FUNC_GET, 3, 32'h0);
      queue_req(FUNC_GET, 4, 32'hFFFF_FFFF);
      queue_req(FUNC_DELETE, 1, 32'h0);
      queue_req(FUNC_DELETE, 0, 32'h0);
      queue_req(FUNC_CLEAR, 0, 32'h0);
      queue_req(FUNC_GET, 0, 32'h0);

      // zero capacity
      write_capacity(CNT_W'(0));
      queue_req(FUNC_INSERT, 0, 32'h1234_5678);
      queue_req(FUNC_DELETE, 0, 32'h0);

      // tiny capacity: range check, then full wins over range
      write_capacity(CNT_W'(2));
      queue_req(FUNC_INSERT, 5, 32'h1111_1111);
      queue_req(FUNC_INSERT, 0, 32'h2222_2222);
      queue_req(FUNC_INSERT, 1, 32'h3333_3333);
      queue_req(FUNC_INSERT, 0, 32'h4444_4444);
      queue_req(FUNC_INSERT, 63, 32'h5555_5555);
      queue_req(FUNC_DELETE, 1, 32'h0);
      queue_req(FUNC_DELETE, 0, 32'h0);

      // capacity above the store depth
      write_capacity(CNT_W'(127));
      queue_req(FUNC_INSERT, 63, 32'hDEAD_BEEF);
      queue_req(FUNC_GET, 0, 32'h0);

      set_idle(0, 0);
      queue_random(60, 55, 2);

      write_capacity(CNT_W'(1));
      set_idle(80, 0);
      queue_random(50, 50, 3);

      // fill to full while the receiver holds off
      write_capacity(CNT_W'(64));
      queue_req(FUNC_CLEAR, 0, 32'h0);
      set_idle(0, 0);
      holds_asked = holds_asked + 1;
      queue_random(100, 85, 0);
      set_idle(13, 13);
      queue_random(40, 20, 0);

      write_capacity(CNT_W'($urandom_range(12, 3)));
      set_idle(0, 80);
      queue_random(60, 50, 3);

      write_capacity(CNT_W'(33));
      set_idle(13, 13);
      queue_random(60, 55, 2);

      write_capacity(CNT_W'($urandom_range(127)));
      set_idle(0, 0);
      queue_random(40, 50, 3);

      wait_settled();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== sim.f =====
design/oal_pkg.sv
design/oal_cell.sv
design/ordered_array_list_unit.sv
tb/tb_ordered_array_list_unit.sv
